/* design/cell_migration_automaton_step_macros.svh */
// Assertion macros shared by the checker of the cell migration block.
`ifndef CELL_MIGRATION_AUTOMATON_STEP_MACROS_SVH
`define CELL_MIGRATION_AUTOMATON_STEP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cma_pkg.sv */
// Types, codes and helper functions of the cell migration automaton.
package cma_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_STAT_PERS = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MOVE_PERS = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_COLL_PERS = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_BOUND_PERS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DIV_PERIOD = 3'd4;

    localparam logic [7:0]  RST_STAT_PERS  = 8'd5;
    localparam logic [7:0]  RST_MOVE_PERS  = 8'd24;
    localparam logic [7:0]  RST_COLL_PERS  = 8'd30;
    localparam logic [7:0]  RST_BOUND_PERS = 8'd10;
    localparam logic [15:0] RST_DIV_PERIOD = 16'd1200;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_VISIT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_DIVIDED    = 3'd1;
    localparam logic [2:0] ACT_STATIONARY = 3'd2;
    localparam logic [2:0] ACT_TURNED     = 3'd3;
    localparam logic [2:0] ACT_MOVED      = 3'd4;
    localparam logic [2:0] ACT_COLLIDED   = 3'd5;
    localparam logic [2:0] ACT_BLOCKED    = 3'd6;
    localparam logic [2:0] ACT_COUNTED    = 3'd7;

    localparam logic [2:0] DIR_STAT  = 3'd0;
    localparam logic [2:0] DIR_EAST  = 3'd1;
    localparam logic [2:0] DIR_SOUTH = 3'd2;
    localparam logic [2:0] DIR_WEST  = 3'd3;
    localparam logic [2:0] DIR_NORTH = 3'd4;
    localparam logic [2:0] DIR_COLL  = 3'd7;

    // Neighbour slots in scan order: row-1, row+1, col-1, col+1.
    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_RIGHT = 2'd3;

    typedef struct packed {
        logic        occupied;
        logic [2:0]  direction;
        logic [7:0]  persistence;
        logic [15:0] division;
        logic        porous;
    } t_cell;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        load_occupied;
        logic [2:0]  load_direction;
        logic [7:0]  load_persistence;
        logic [15:0] load_division;
        logic        load_porous;
        logic [15:0] pick_random;
        logic [1:0]  self_dir_random;
        logic [1:0]  child_dir_random;
    } t_in;

    typedef struct packed {
        logic [2:0]  action;
        logic        occupied;
        logic [2:0]  direction;
        logic [7:0]  persistence;
        logic [15:0] division_count;
        logic        porous;
        logic [5:0]  target_row;
        logic [5:0]  target_col;
    } t_out;

    // Step code taken by a cell that moves into a neighbour slot.
    function automatic logic [2:0] slot_dir(input logic [1:0] k);
        logic [2:0] d;
        case (k)
            NB_UP:   d = DIR_NORTH;
            NB_DOWN: d = DIR_SOUTH;
            NB_LEFT: d = DIR_WEST;
            default: d = DIR_EAST;
        endcase
        return d;
    endfunction

    // Remainder by three: base-4 digits are summed since 4 is 1 modulo 3.
    function automatic logic [1:0] mod3_u16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int j = 0; j < 8; j++) begin
            s = s + 5'(v[2*j +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

/* design/cma_in_if.sv */
// Request channel carrying one operation on the cell grid.
interface cma_in_if;
    import cma_pkg::*;

    logic valid;
    logic ready;
    t_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/cma_out_if.sv */
// Result channel carrying the outcome of one operation.
interface cma_out_if;
    import cma_pkg::*;

    logic valid;
    logic ready;
    t_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/cell_migration_automaton_step.sv */
// Cell migration automaton: grid memory with a read-modify-write sequencer.
//
// Usage. Requests arrive on i_in as valid/ready transactions; each request
// produces exactly one result transaction on o_out. Configuration registers
// are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write
// them only while the block is idle, which the block itself does not
// enforce. The grid record of every site lives in one synchronous memory,
// and the visit marks in a second one, both with registered read data. A
// visit reads the site and its four neighbours one per cycle, then decides,
// then writes the site and at most one neighbour, one write per cycle, and
// then registers its result; the next request is taken after that. A read
// fetches only the site, and a load writes it without reading. Starting a
// tick rewrites every visit mark, one site per cycle, before its result
// comes. After reset the block runs a clearing pass over every site of both
// memories and accepts no request until it is done; configuration writes
// are taken throughout. The result sits in an output register: the next
// request is accepted while it waits, and that request stalls only at its
// own end until the receiver takes it.
module cell_migration_automaton_step #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cma_in_if.sink                        i_in,
    cma_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [cma_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [cma_pkg::CfgDataW-1:0]  i_cfg_data
);
    import cma_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam logic [8:0]    ROWS9 = 9'(GRID_ROWS);
    localparam logic [8:0]    COLS9 = 9'(GRID_COLS);
    localparam logic [AW-1:0] LAST_SITE = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_RD, S_CALC, S_WR1, S_WR2, S_DONE
    } t_state;

    // Configuration.
    logic [7:0]  r_stat_pers, r_move_pers, r_coll_pers, r_bound_pers;
    logic [15:0] r_div_period;

    // Sequencer state.
    t_state      r_state;
    logic [2:0]  r_k;
    logic [AW-1:0] r_sweep;
    logic        r_clr;
    logic        r_parity;

    // Captured request.
    logic [1:0]  r_op;
    logic [5:0]  r_row, r_col;
    logic [15:0] r_pick;
    logic [1:0]  r_sd, r_cd;
    logic        r_ingrid;

    // Records read from memory.
    t_cell       r_self;
    logic        r_mark;
    t_cell       r_nb [4];

    // Decided writes.
    t_cell       r_w1, r_w2, r_own;
    logic        r_we1, r_we2;
    logic [1:0]  r_w2_k;
    logic [2:0]  r_act;

    // Output register.
    logic        r_out_valid;
    t_out        r_out;

    // Memories.
    t_cell       mem_rec [CELLS];
    logic        mem_mark [CELLS];
    t_cell       r_rd_rec;
    logic        r_rd_mark;
    logic [AW-1:0] mem_ra, mem_wa, mark_wa;
    logic        mem_we, mark_we, mark_wd;
    t_cell       mem_wd;

    // Neighbour geometry from the captured coordinates.
    logic [8:0]  nb_r [4];
    logic [8:0]  nb_c [4];
    logic [3:0]  nb_in;
    logic [AW-1:0] nb_a [4];
    logic [AW-1:0] self_a;
    logic [17:0] lin [5];

    always_comb begin
        nb_r[NB_UP]    = {3'b0, r_row} - 9'd1;
        nb_c[NB_UP]    = {3'b0, r_col};
        nb_r[NB_DOWN]  = {3'b0, r_row} + 9'd1;
        nb_c[NB_DOWN]  = {3'b0, r_col};
        nb_r[NB_LEFT]  = {3'b0, r_row};
        nb_c[NB_LEFT]  = {3'b0, r_col} - 9'd1;
        nb_r[NB_RIGHT] = {3'b0, r_row};
        nb_c[NB_RIGHT] = {3'b0, r_col} + 9'd1;
        nb_in[NB_UP]    = (r_row != 6'd0);
        nb_in[NB_DOWN]  = (nb_r[NB_DOWN] < ROWS9);
        nb_in[NB_LEFT]  = (r_col != 6'd0);
        nb_in[NB_RIGHT] = (nb_c[NB_RIGHT] < COLS9);
        lin[4] = 18'({3'b0, r_row}) * 18'(COLS9) + 18'({3'b0, r_col});
        self_a = lin[4][AW-1:0];
        for (int k = 0; k < 4; k++) begin
            lin[k]  = 18'(nb_r[k]) * 18'(COLS9) + 18'(nb_c[k]);
            nb_a[k] = lin[k][AW-1:0];
        end
    end

    // Memory ports.
    always_comb begin
        case (r_k)
            3'd1:    mem_ra = nb_a[NB_UP];
            3'd2:    mem_ra = nb_a[NB_DOWN];
            3'd3:    mem_ra = nb_a[NB_LEFT];
            3'd4:    mem_ra = nb_a[NB_RIGHT];
            default: mem_ra = self_a;
        endcase
        mem_we  = 1'b0;
        mem_wa  = self_a;
        mem_wd  = r_w1;
        mark_we = 1'b0;
        mark_wa = nb_a[r_w2_k];
        mark_wd = r_parity;
        case (r_state)
            S_SWEEP: begin
                mem_we  = r_clr;
                mem_wa  = r_sweep;
                mem_wd  = '0;
                mark_we = 1'b1;
                mark_wa = r_sweep;
                mark_wd = ~r_parity;
            end
            S_WR1: begin
                mem_we = r_we1;
            end
            S_WR2: begin
                mem_we  = r_we2;
                mem_wa  = nb_a[r_w2_k];
                mem_wd  = r_w2;
                mark_we = r_we2;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_rec[mem_wa] <= mem_wd;
        end
        r_rd_rec <= mem_rec[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mem_mark[mark_wa] <= mark_wd;
        end
        r_rd_mark <= mem_mark[mem_ra];
    end

    // Update rule, evaluated from the captured records.
    logic [3:0]  free;
    logic [2:0]  n_free;
    logic [1:0]  pick_p, sel_k, kd, c_k, cnt;
    logic [15:0] dv, nb_dv;
    logic [7:0]  pv;
    logic        visitable, dir_move;
    t_cell       c_w1, c_w2;
    logic        c_we1, c_we2;
    logic [2:0]  c_act;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            free[k] = nb_in[k] && !r_nb[k].occupied && !r_nb[k].porous;
        end
        n_free = 3'($countones(free));
        case (n_free)
            3'd2:    pick_p = {1'b0, r_pick[0]};
            3'd3:    pick_p = mod3_u16(r_pick);
            3'd4:    pick_p = r_pick[1:0];
            default: pick_p = 2'd0;
        endcase
        sel_k = 2'd0;
        cnt   = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (free[k]) begin
                if (cnt == pick_p) begin
                    sel_k = 2'(k);
                end
                cnt = cnt + 2'd1;
            end
        end
        case (r_self.direction)
            DIR_EAST:  kd = NB_RIGHT;
            DIR_SOUTH: kd = NB_DOWN;
            DIR_WEST:  kd = NB_LEFT;
            default:   kd = NB_UP;
        endcase
        dir_move = (r_self.direction >= DIR_EAST) && (r_self.direction <= DIR_NORTH);
        dv    = r_self.division - 16'd1;
        pv    = r_self.persistence - 8'd1;
        nb_dv = (r_nb[kd].division != 16'd0) ? r_nb[kd].division - 16'd1 : 16'd0;
        visitable = (r_op == OP_VISIT) && r_self.occupied && !r_self.porous
                    && (r_mark != r_parity);

        c_act = ACT_NONE;
        c_we1 = 1'b0;
        c_we2 = 1'b0;
        c_k   = sel_k;
        c_w1  = r_self;
        c_w2  = r_nb[sel_k];
        if (visitable) begin
            c_we1 = 1'b1;
            if (r_self.division == 16'd0) begin
                if (n_free == 3'd0) begin
                    c_w1.occupied    = 1'b1;
                    c_w1.direction   = DIR_STAT;
                    c_w1.persistence = r_stat_pers;
                    c_act = ACT_STATIONARY;
                end else begin
                    c_w1.direction   = {1'b0, r_sd} + 3'd1;
                    c_w1.persistence = r_move_pers;
                    c_w1.division    = r_div_period;
                    c_w2.occupied    = 1'b1;
                    c_w2.direction   = {1'b0, r_cd} + 3'd1;
                    c_w2.persistence = r_move_pers;
                    c_w2.division    = r_div_period;
                    c_we2 = 1'b1;
                    c_act = ACT_DIVIDED;
                end
            end else if (r_self.persistence == 8'd0) begin
                if (n_free == 3'd0) begin
                    c_w1.occupied    = 1'b1;
                    c_w1.direction   = DIR_STAT;
                    c_w1.persistence = r_stat_pers;
                    c_w1.division    = dv;
                    c_act = ACT_STATIONARY;
                end else begin
                    c_w2.occupied    = 1'b1;
                    c_w2.direction   = slot_dir(sel_k);
                    c_w2.persistence = r_move_pers;
                    c_w2.division    = dv;
                    c_w1 = '0;
                    c_w1.porous = r_self.porous;
                    c_we2 = 1'b1;
                    c_act = ACT_TURNED;
                end
            end else if (!dir_move) begin
                c_w1.persistence = pv;
                c_w1.division    = dv;
                c_act = ACT_COUNTED;
            end else begin
                c_k = kd;
                if (!nb_in[kd] || r_nb[kd].porous) begin
                    c_w1.direction   = DIR_COLL;
                    c_w1.persistence = r_bound_pers;
                    c_w1.division    = dv;
                    c_act = ACT_BLOCKED;
                end else if (!r_nb[kd].occupied) begin
                    c_w2 = r_nb[kd];
                    c_w2.occupied    = 1'b1;
                    c_w2.direction   = r_self.direction;
                    c_w2.persistence = pv;
                    c_w2.division    = dv;
                    c_w1 = '0;
                    c_w1.porous = r_self.porous;
                    c_we2 = 1'b1;
                    c_act = ACT_MOVED;
                end else begin
                    c_w1.direction   = DIR_COLL;
                    c_w1.persistence = r_coll_pers;
                    c_w1.division    = dv;
                    c_w2 = r_nb[kd];
                    c_w2.direction   = DIR_COLL;
                    c_w2.persistence = r_coll_pers;
                    c_w2.division    = nb_dv;
                    c_we2 = 1'b1;
                    c_act = ACT_COLLIDED;
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_pers  <= RST_STAT_PERS;
            r_move_pers  <= RST_MOVE_PERS;
            r_coll_pers  <= RST_COLL_PERS;
            r_bound_pers <= RST_BOUND_PERS;
            r_div_period <= RST_DIV_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STAT_PERS:  r_stat_pers  <= i_cfg_data[7:0];
                CFG_MOVE_PERS:  r_move_pers  <= i_cfg_data[7:0];
                CFG_COLL_PERS:  r_coll_pers  <= i_cfg_data[7:0];
                CFG_BOUND_PERS: r_bound_pers <= i_cfg_data[7:0];
                CFG_DIV_PERIOD: r_div_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output register.
    logic       in_fire;
    logic       in_grid;
    logic [2:0] last_k;

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_fire       = i_in.valid && (r_state == S_IDLE);
    assign in_grid       = ({3'b0, i_in.payload.row} < ROWS9)
                           && ({3'b0, i_in.payload.col} < COLS9);
    assign last_k        = (r_op == OP_VISIT) ? 3'd5 : 3'd1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_clr       <= 1'b1;
            r_sweep     <= '0;
            r_parity    <= 1'b1;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is handled below.
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (r_sweep == LAST_SITE) begin
                        r_sweep <= '0;
                        r_k     <= '0;
                        if (r_clr) begin
                            r_state <= S_IDLE;
                        end else if (r_ingrid) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_sweep <= r_sweep + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op     <= i_in.payload.op;
                        r_row    <= i_in.payload.row;
                        r_col    <= i_in.payload.col;
                        r_pick   <= i_in.payload.pick_random;
                        r_sd     <= i_in.payload.self_dir_random;
                        r_cd     <= i_in.payload.child_dir_random;
                        r_ingrid <= in_grid;
                        r_we1    <= (i_in.payload.op == OP_LOAD);
                        r_we2    <= 1'b0;
                        r_act    <= ACT_NONE;
                        r_k      <= '0;
                        r_w1.occupied    <= i_in.payload.load_occupied;
                        r_w1.direction   <= i_in.payload.load_direction;
                        r_w1.persistence <= i_in.payload.load_persistence;
                        r_w1.division    <= i_in.payload.load_division;
                        r_w1.porous      <= i_in.payload.load_porous;
                        r_own.occupied    <= i_in.payload.load_occupied;
                        r_own.direction   <= i_in.payload.load_direction;
                        r_own.persistence <= i_in.payload.load_persistence;
                        r_own.division    <= i_in.payload.load_division;
                        r_own.porous      <= i_in.payload.load_porous;
                        if (i_in.payload.op == OP_TICK) begin
                            r_parity <= ~r_parity;
                            r_clr    <= 1'b0;
                            r_state  <= S_SWEEP;
                        end else if (!in_grid) begin
                            r_state <= S_DONE;
                        end else if (i_in.payload.op == OP_LOAD) begin
                            r_state <= S_WR1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    case (r_k)
                        3'd1: begin
                            r_self <= r_rd_rec;
                            r_mark <= r_rd_mark;
                        end
                        3'd2:    r_nb[NB_UP]    <= r_rd_rec;
                        3'd3:    r_nb[NB_DOWN]  <= r_rd_rec;
                        3'd4:    r_nb[NB_LEFT]  <= r_rd_rec;
                        3'd5:    r_nb[NB_RIGHT] <= r_rd_rec;
                        default: begin
                        end
                    endcase
                    if (r_k == last_k) begin
                        r_state <= S_CALC;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_CALC: begin
                    r_w1   <= c_w1;
                    r_w2   <= c_w2;
                    r_we1  <= c_we1;
                    r_we2  <= c_we2;
                    r_w2_k <= c_k;
                    r_act  <= c_act;
                    r_own  <= c_we1 ? c_w1 : r_self;
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out.action <= r_act;
                        if (r_ingrid) begin
                            r_out.occupied       <= r_own.occupied;
                            r_out.direction      <= r_own.direction;
                            r_out.persistence    <= r_own.persistence;
                            r_out.division_count <= r_own.division;
                            r_out.porous         <= r_own.porous;
                        end else begin
                            r_out.occupied       <= 1'b0;
                            r_out.direction      <= DIR_STAT;
                            r_out.persistence    <= '0;
                            r_out.division_count <= '0;
                            r_out.porous         <= 1'b0;
                        end
                        if (r_we2) begin
                            r_out.target_row <= nb_r[r_w2_k][5:0];
                            r_out.target_col <= nb_c[r_w2_k][5:0];
                        end else begin
                            r_out.target_row <= r_row;
                            r_out.target_col <= r_col;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/cma_checker.sv */
// Port-level checker for the cell migration block, bound to the top level.
`include "cell_migration_automaton_step_macros.svh"

module cma_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input cma_pkg::t_out i_out_payload
);
    import cma_pkg::*;

    `CMA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "stalled result changed")
    `CMA_ASSERT_NOW(a_divide_stays, i_out_valid && (i_out_payload.action == ACT_DIVIDED), i_out_payload.occupied && (i_out_payload.direction >= DIR_EAST) && (i_out_payload.direction <= DIR_NORTH), "divided cell not moving")
    `CMA_ASSERT_NOW(a_leave_clears, i_out_valid && ((i_out_payload.action == ACT_MOVED) || (i_out_payload.action == ACT_TURNED)), !i_out_payload.occupied, "vacated site still occupied")
    `CMA_ASSERT_NOW(a_collide_dir, i_out_valid && ((i_out_payload.action == ACT_COLLIDED) || (i_out_payload.action == ACT_BLOCKED)), i_out_payload.direction == DIR_COLL, "collided cell lacks collided direction")

endmodule

bind cell_migration_automaton_step cma_checker u_cma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

/* test/tb_top.sv */
// Self-checking testbench for the cell migration automaton, driven through its request channel.
`timescale 1ns / 1ps

module tb_top;
    import cma_pkg::*;

    localparam int Cells = 64 * 64;
    localparam int ClkHalf = 6;

    // One row of the directed table. When has_exp is set, the expected result
    // is typed in. Otherwise the grid predictor supplies it.
    typedef struct {
        t_in  req;
        bit   has_exp;
        t_out exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    cma_in_if  req_if ();
    cma_out_if res_if ();

    cell_migration_automaton_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if.sink),
        .o_out      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The testbench keeps its own copy of the grid, the tick parity and the
    // configuration registers.
    logic        g_occ  [Cells];
    logic [2:0]  g_dir  [Cells];
    logic [7:0]  g_pers [Cells];
    logic [15:0] g_div  [Cells];
    logic        g_por  [Cells];
    logic        g_mark [Cells];
    logic        parity;
    logic [7:0]  stat_pers, move_pers, coll_pers, bound_pers;
    logic [15:0] div_period;

    t_out expected_results[$];
    int   mismatches;
    int   results_seen;
    int   action_seen[8];
    int   requests_sent;
    int   ticks_sent;

    // The sender and the receiver share these handshake controls. When
    // no_gaps is set, both sides run without idle cycles. hold_cycles makes
    // the receiver hold off for a long stretch.
    bit   no_gaps;
    int   hold_cycles;
    int   stall_left;

    initial begin
        i_clk = 1'b0;
        forever begin
            #ClkHalf i_clk = ~i_clk;
        end
    end

    // The run stops here if the handshakes ever stop making progress.
    initial begin
        #(64'd2_000_000 * 2 * ClkHalf);
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit site_free(int r, int c);
        if (r < 0 || r > 63 || c < 0 || c > 63) begin
            return 1'b0;
        end
        return !g_occ[r*64+c] && !g_por[r*64+c];
    endfunction

    // This function lists the free neighbours in scan order: up, down,
    // left, right. Each neighbour comes with the direction code of the
    // step that reaches it.
    function automatic int list_free(int r, int c, output int nr[4], output int nc[4],
                                     output logic [2:0] nd[4]);
        int dr[4];
        int dc[4];
        logic [2:0] code[4];
        int n;
        dr = '{-1, 1, 0, 0};
        dc = '{0, 0, -1, 1};
        code = '{DIR_NORTH, DIR_SOUTH, DIR_WEST, DIR_EAST};
        n = 0;
        for (int k = 0; k < 4; k++) begin
            nr[k] = 0;
            nc[k] = 0;
            nd[k] = DIR_STAT;
        end
        for (int k = 0; k < 4; k++) begin
            if (site_free(r + dr[k], c + dc[k])) begin
                nr[n] = r + dr[k];
                nc[n] = c + dc[k];
                nd[n] = code[k];
                n++;
            end
        end
        return n;
    endfunction

    // This function applies one request to the grid copy and returns the
    // result that the block must produce for it.
    function automatic t_out grid_step(t_in x);
        t_out o;
        int r, c, i, t, n, p, mr, mc, tr, tc;
        int nr[4];
        int nc[4];
        logic [2:0] nd[4];
        logic [2:0] d;
        logic [2:0] act;
        r = x.row;
        c = x.col;
        i = r * 64 + c;
        tr = r;
        tc = c;
        act = ACT_NONE;
        case (x.op)
            OP_TICK: begin
                parity = ~parity;
                for (int k = 0; k < Cells; k++) begin
                    g_mark[k] = ~parity;
                end
            end
            OP_LOAD: begin
                g_occ[i]  = x.load_occupied;
                g_dir[i]  = x.load_direction;
                g_pers[i] = x.load_persistence;
                g_div[i]  = x.load_division;
                g_por[i]  = x.load_porous;
            end
            OP_VISIT: begin
                // Empty, porous or already visited sites are left alone.
                if (!g_por[i] && g_mark[i] != parity && g_occ[i]) begin
                    if (g_div[i] == 0) begin
                        n = list_free(r, c, nr, nc, nd);
                        if (n == 0) begin
                            g_dir[i] = DIR_STAT;
                            g_pers[i] = stat_pers;
                            act = ACT_STATIONARY;
                        end else begin
                            // A division puts a daughter cell into one free
                            // neighbour.
                            p = x.pick_random % n;
                            t = nr[p] * 64 + nc[p];
                            g_dir[i]  = 3'(x.self_dir_random) + 3'd1;
                            g_pers[i] = move_pers;
                            g_div[i]  = div_period;
                            g_occ[t]  = 1'b1;
                            g_dir[t]  = 3'(x.child_dir_random) + 3'd1;
                            g_pers[t] = move_pers;
                            g_div[t]  = div_period;
                            g_mark[t] = parity;
                            tr = nr[p];
                            tc = nc[p];
                            act = ACT_DIVIDED;
                        end
                    end else begin
                        g_div[i] = g_div[i] - 16'd1;
                        if (g_pers[i] == 0) begin
                            n = list_free(r, c, nr, nc, nd);
                            if (n == 0) begin
                                g_dir[i] = DIR_STAT;
                                g_pers[i] = stat_pers;
                                act = ACT_STATIONARY;
                            end else begin
                                // The cell turns into a random free
                                // neighbour and takes that step's direction.
                                p = x.pick_random % n;
                                t = nr[p] * 64 + nc[p];
                                g_occ[t]  = 1'b1;
                                g_dir[t]  = nd[p];
                                g_pers[t] = move_pers;
                                g_div[t]  = g_div[i];
                                g_occ[i]  = 1'b0;
                                g_dir[i]  = DIR_STAT;
                                g_pers[i] = '0;
                                g_div[i]  = '0;
                                g_mark[t] = parity;
                                tr = nr[p];
                                tc = nc[p];
                                act = ACT_TURNED;
                            end
                        end else begin
                            g_pers[i] = g_pers[i] - 8'd1;
                            d = g_dir[i];
                            mr = r;
                            mc = c;
                            case (d)
                                DIR_EAST:  mc = c + 1;
                                DIR_SOUTH: mr = r + 1;
                                DIR_WEST:  mc = c - 1;
                                DIR_NORTH: mr = r - 1;
                                default:   act = ACT_COUNTED;
                            endcase
                            if (act != ACT_COUNTED) begin
                                if (mr < 0 || mr > 63 || mc < 0 || mc > 63 ||
                                    g_por[mr*64+mc]) begin
                                    g_dir[i] = DIR_COLL;
                                    g_pers[i] = bound_pers;
                                    act = ACT_BLOCKED;
                                end else begin
                                    t = mr * 64 + mc;
                                    tr = mr;
                                    tc = mc;
                                    if (!g_occ[t]) begin
                                        g_occ[t]  = 1'b1;
                                        g_dir[t]  = d;
                                        g_pers[t] = g_pers[i];
                                        g_div[t]  = g_div[i];
                                        g_occ[i]  = 1'b0;
                                        g_dir[i]  = DIR_STAT;
                                        g_pers[i] = '0;
                                        g_div[i]  = '0;
                                        act = ACT_MOVED;
                                    end else begin
                                        // In a collision, both cells stop. The
                                        // division count of the hit cell stops
                                        // at zero.
                                        g_dir[i]  = DIR_COLL;
                                        g_pers[i] = coll_pers;
                                        g_dir[t]  = DIR_COLL;
                                        g_pers[t] = coll_pers;
                                        if (g_div[t] != 0) begin
                                            g_div[t] = g_div[t] - 16'd1;
                                        end
                                        act = ACT_COLLIDED;
                                    end
                                    g_mark[t] = parity;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        o.action         = act;
        o.occupied       = g_occ[i];
        o.direction      = g_dir[i];
        o.persistence    = g_pers[i];
        o.division_count = g_div[i];
        o.porous         = g_por[i];
        o.target_row     = 6'(tr);
        o.target_col     = 6'(tc);
        return o;
    endfunction

    function automatic t_in make_req(logic [1:0] op, int r, int c, bit occ, int d, int pers,
                                     int dv, bit por, int pick, int sd, int cd);
        t_in x;
        x.op = op;
        x.row = 6'(r);
        x.col = 6'(c);
        x.load_occupied = occ;
        x.load_direction = 3'(d);
        x.load_persistence = 8'(pers);
        x.load_division = 16'(dv);
        x.load_porous = por;
        x.pick_random = 16'(pick);
        x.self_dir_random = 2'(sd);
        x.child_dir_random = 2'(cd);
        return x;
    endfunction

    function automatic t_out make_res(logic [2:0] act, bit occ, int d, int pers, int dv,
                                      bit por, int tr, int tc);
        t_out o;
        o.action = act;
        o.occupied = occ;
        o.direction = 3'(d);
        o.persistence = 8'(pers);
        o.division_count = 16'(dv);
        o.porous = por;
        o.target_row = 6'(tr);
        o.target_col = 6'(tc);
        return o;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t: result %0d field %s is %0d, expected %0d",
                     $realtime, results_seen, field, got, want);
        end
    endtask

    // This task offers one request after a random gap and waits for it to be
    // accepted. The expectation is queued at the accepting clock edge.
    task automatic send_request(t_in x, bit has_exp, t_out typed);
        int gap;
        t_out predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.payload <= x;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = grid_step(x);
        expected_results.push_back(has_exp ? typed : predicted);
        requests_sent++;
        if (x.op == OP_TICK) begin
            ticks_sent++;
        end
    endtask

    // A configuration change waits until every expected result is out, plus a
    // margin that covers a visit still writing back.
    task automatic write_config(int stat, int move, int coll, int bound, int dv);
        logic [15:0] vals[5];
        vals = '{16'(stat), 16'(move), 16'(coll), 16'(bound), 16'(dv)};
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (20) @(negedge i_clk);
        for (int k = 0; k < 5; k++) begin
            cfg_we <= 1'b1;
            cfg_idx <= CfgIdxW'(k);
            cfg_data <= vals[k];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        stat_pers = vals[0][7:0];
        move_pers = vals[1][7:0];
        coll_pers = vals[2][7:0];
        bound_pers = vals[3][7:0];
        div_period = vals[4];
    endtask

    // Random requests mostly fall inside a small window, so that cells meet,
    // collide and crowd each other. The remaining requests spread over the
    // whole grid.
    function automatic t_in random_req(int base_r, int base_c);
        int pct, r, c, pers, dv;
        logic [1:0] op;
        pct = $urandom_range(0, 99);
        if (pct < 2) op = OP_TICK;
        else if (pct < 35) op = OP_LOAD;
        else if (pct < 90) op = OP_VISIT;
        else op = OP_READ;
        if ($urandom_range(0, 9) == 0) begin
            r = $urandom_range(0, 63);
            c = $urandom_range(0, 63);
        end else begin
            r = base_r + $urandom_range(0, 5);
            c = base_c + $urandom_range(0, 5);
        end
        pers = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        dv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
        return make_req(op, r, c, $urandom_range(0, 4) != 0, $urandom_range(0, 7), pers, dv,
                        $urandom_range(0, 9) == 0, $urandom_range(0, 65535),
                        $urandom_range(0, 3), $urandom_range(0, 3));
    endfunction

    // The receiver stalls at random, and it holds off for a long stretch
    // when the stimulus asks for it.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Each result transaction is compared field by field with the oldest
    // expected result.
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.payload;
            results_seen++;
            stall_left = no_gaps ? 0 : $urandom_range(0, 10);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected", 1, 0);
            end else begin
                want = expected_results.pop_front();
                action_seen[want.action]++;
                if (got.action !== want.action)
                    report_mismatch("action", got.action, want.action);
                if (got.occupied !== want.occupied)
                    report_mismatch("occupied", got.occupied, want.occupied);
                if (got.direction !== want.direction)
                    report_mismatch("direction", got.direction, want.direction);
                if (got.persistence !== want.persistence)
                    report_mismatch("persistence", got.persistence, want.persistence);
                if (got.division_count !== want.division_count)
                    report_mismatch("division_count", got.division_count,
                                    want.division_count);
                if (got.porous !== want.porous)
                    report_mismatch("porous", got.porous, want.porous);
                if (got.target_row !== want.target_row)
                    report_mismatch("target_row", got.target_row, want.target_row);
                if (got.target_col !== want.target_col)
                    report_mismatch("target_col", got.target_col, want.target_col);
            end
        end
    end

    initial begin
        t_row rows[$];
        t_out none_res;
        int base_r, base_c, wait_count;
        none_res = make_res(ACT_NONE, 0, 0, 0, 0, 0, 0, 0);

        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        hold_cycles = 0;
        stall_left = 0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        ticks_sent = 0;
        foreach (action_seen[k]) action_seen[k] = 0;
        for (int k = 0; k < Cells; k++) begin
            g_occ[k] = 0;
            g_dir[k] = 0;
            g_pers[k] = 0;
            g_div[k] = 0;
            g_por[k] = 0;
            g_mark[k] = 0;
        end
        parity = 1'b1;
        stat_pers = RST_STAT_PERS;
        move_pers = RST_MOVE_PERS;
        coll_pers = RST_COLL_PERS;
        bound_pers = RST_BOUND_PERS;
        div_period = RST_DIV_PERIOD;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // In the directed part, the registers keep their reset values.
        // A freshly cleared grid reads as all zeros.
        rows.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none_res});
        rows.push_back('{make_req(OP_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_res(ACT_NONE, 0, 0, 0, 0, 0, 63, 63)});
        // A load with every field at its maximum makes a porous corner site.
        // Visiting that site does nothing.
        rows.push_back('{make_req(OP_LOAD, 63, 63, 1, 7, 255, 65535, 1, 0, 0, 0), 1,
                         make_res(ACT_NONE, 1, 7, 255, 65535, 1, 63, 63)});
        rows.push_back('{make_req(OP_VISIT, 63, 63, 0, 0, 0, 0, 0, 65535, 3, 3), 1,
                         make_res(ACT_NONE, 1, 7, 255, 65535, 1, 63, 63)});
        // A cell that heads north from row zero is blocked by the edge.
        rows.push_back('{make_req(OP_LOAD, 0, 0, 1, 4, 3, 5, 0, 0, 0, 0), 1,
                         make_res(ACT_NONE, 1, 4, 3, 5, 0, 0, 0)});
        rows.push_back('{make_req(OP_VISIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         make_res(ACT_BLOCKED, 1, 7, 10, 4, 0, 0, 0)});
        // When its direction is collided, the cell only counts down.
        rows.push_back('{make_req(OP_VISIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        // A cell divides into one of its free neighbours. The daughter cell
        // is marked, so a second visit to it in the same tick does nothing.
        rows.push_back('{make_req(OP_LOAD, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 0, 1, 0, 0, 0, 0, 0, 1, 3, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        // A new tick clears the marks, so the daughter cell can move.
        rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        // A cell with zero persistence turns into a random free neighbour.
        rows.push_back('{make_req(OP_LOAD, 5, 5, 1, 1, 0, 10, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 5, 5, 0, 0, 0, 0, 0, 65535, 0, 0), 0, none_res});
        // A collision with a cell whose division count is already zero
        // leaves that count at zero.
        rows.push_back('{make_req(OP_LOAD, 10, 10, 1, 1, 5, 3, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_LOAD, 10, 11, 1, 0, 1, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 10, 10, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_READ, 10, 11, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        // A dividing cell with no free neighbour goes stationary instead.
        rows.push_back('{make_req(OP_LOAD, 19, 20, 0, 0, 0, 0, 1, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_LOAD, 21, 20, 0, 0, 0, 0, 1, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_LOAD, 20, 19, 1, 0, 9, 9, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_LOAD, 20, 21, 1, 0, 9, 9, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_LOAD, 20, 20, 1, 2, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 20, 20, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        // A direction code that has no meaning only counts down, and so does a
        // stationary cell. A visit to an empty site does nothing.
        rows.push_back('{make_req(OP_LOAD, 30, 30, 1, 5, 4, 2, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 30, 30, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 20, 19, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});
        rows.push_back('{make_req(OP_VISIT, 40, 40, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res});

        foreach (rows[k]) begin
            send_request(rows[k].req, rows[k].has_exp, rows[k].exp);
        end

        // The random part runs through four register settings: both
        // extremes, one with a short division period, and one drawn at
        // random.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_config(0, 0, 0, 0, 0);
                1: write_config(255, 255, 255, 255, 65535);
                2: write_config(3, 4, 2, 1, 2);
                default: write_config($urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 65535));
            endcase
            for (int n = 0; n < 380; n++) begin
                if (n % 60 == 0) begin
                    base_r = $urandom_range(0, 1) ? 58 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 58);
                    base_c = $urandom_range(0, 1) ? 58 * $urandom_range(0, 1)
                                                  : $urandom_range(0, 58);
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                // In the second setting, the receiver holds off for a long
                // time while requests keep coming with no gaps.
                if (phase == 1 && n == 100) begin
                    hold_cycles = 400;
                    no_gaps = 1'b1;
                end
                send_request(random_req(base_r, base_c), 0, none_res);
            end
        end

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        wait_count = 0;
        while (expected_results.size() != 0 && wait_count < 200000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (30) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("missing", expected_results.size(), 0);
        end

        $display("Ran %0d requests, %0d of them ticks, and checked %0d results.",
                 requests_sent, ticks_sent, results_seen);
        $display("Actions: divided %0d, stationary %0d, turned %0d, moved %0d, collided %0d,",
                 action_seen[1], action_seen[2], action_seen[3], action_seen[4],
                 action_seen[5]);
        $display("blocked %0d, counted %0d, other %0d; %0d mismatches.", action_seen[6],
                 action_seen[7], action_seen[0], mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/cma_pkg.sv
design/cma_in_if.sv
design/cma_out_if.sv
design/cell_migration_automaton_step.sv
design/cma_checker.sv
test/tb_top.sv
